FILE: rtl/rds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_pkg
// Types, codes and constants shared by the relay dose sequencer files.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int unsigned SEC_W     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RELAY_W   = 4;
  localparam int unsigned LED_W     = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [SEC_W-1:0] SETTLE_SECONDS_DEF = 8'd3;

  localparam logic [SEC_W-1:0] LOAD_SECONDS_RST   = 8'd5;
  localparam logic [SEC_W-1:0] POISON_SECONDS_RST = 8'd8;
  localparam logic [SEC_W-1:0] RINSE_SECONDS_RST  = 8'd17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_SECONDS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POISON_SECONDS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RINSE_SECONDS  = 8'd2;

  // command and reply characters
  localparam logic [BYTE_W-1:0] CH_STATUS = 8'h53; // 'S'
  localparam logic [BYTE_W-1:0] CH_RAIN   = 8'h4C; // 'L'
  localparam logic [BYTE_W-1:0] CH_FORCED = 8'h46; // 'F'
  localparam logic [BYTE_W-1:0] CH_DOSE   = 8'h44; // 'D'
  localparam logic [BYTE_W-1:0] CH_PANIC  = 8'h50; // 'P'
  localparam logic [BYTE_W-1:0] CH_VOID   = 8'h56; // 'V'

  // active-low led codes
  localparam logic [LED_W-1:0] LED_BUSY   = 3'd2;
  localparam logic [LED_W-1:0] LED_EMPTY  = 3'd6;
  localparam logic [LED_W-1:0] LED_BYPASS = 3'd3;
  localparam logic [LED_W-1:0] LED_RAIN   = 3'd0;
  localparam logic [LED_W-1:0] LED_READY  = 3'd5;

  // relay patterns: bit0 pump, bit1 valve, bit2 poison, bit3 spare
  localparam logic [RELAY_W-1:0] RELAY_OFF    = 4'h0;
  localparam logic [RELAY_W-1:0] RELAY_WATER  = 4'h3;
  localparam logic [RELAY_W-1:0] RELAY_POISON = 4'h7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LOAD   = 3'd1,
    PH_POISON = 3'd2,
    PH_RINSE  = 3'd3,
    PH_SETTLE = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [SEC_W-1:0] seconds_left;
    logic             tank_empty;
    logic             forced_pending;
  } rds_state_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] msg_byte;
    logic              rain_wet;
    logic              sensor_enabled;
    logic              force_request;
  } rds_item_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relays_on;
    logic               reply_valid;
    logic [BYTE_W-1:0]  reply_char;
    logic [LED_W-1:0]   led_n;
    logic               busy_res;
    logic               dropped;
  } rds_res_t;

endpackage
`default_nettype wire

FILE: rtl/rds_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_in_if
// Input item channel: ticks and received command bytes.
// ----------------------------------------------------------------------------
interface rds_in_if;
  import rds_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] msg_byte;
  logic              rain_wet;
  logic              sensor_enabled;
  logic              force_request;

  modport source (
    output valid, cmd, msg_byte, rain_wet, sensor_enabled, force_request,
    input  ready
  );

  modport sink (
    input  valid, cmd, msg_byte, rain_wet, sensor_enabled, force_request,
    output ready
  );

endinterface
`default_nettype wire

FILE: rtl/rds_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_out_if
// Result item channel: relay, reply and led status.
// ----------------------------------------------------------------------------
interface rds_out_if;
  import rds_pkg::*;

  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] relays_on;
  logic               reply_valid;
  logic [BYTE_W-1:0]  reply_char;
  logic [LED_W-1:0]   led_n;
  logic               busy_res;
  logic               dropped;

  modport source (
    output valid, relays_on, reply_valid, reply_char, led_n, busy_res, dropped,
    input  ready
  );

  modport sink (
    input  valid, relays_on, reply_valid, reply_char, led_n, busy_res, dropped,
    output ready
  );

endinterface
`default_nettype wire

FILE: rtl/rds_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rds_cfg_if;
  import rds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface
`default_nettype wire

FILE: rtl/rds_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_step
// Next-state and result logic for one item: command decode, phase timer,
// zero-length phase skipping, reply and led selection.
// ----------------------------------------------------------------------------
module rds_step import rds_pkg::*; (
  input  rds_state_t       st,
  input  rds_item_t        item,
  input  logic [SEC_W-1:0] load_sec,
  input  logic [SEC_W-1:0] poison_sec,
  input  logic [SEC_W-1:0] rinse_sec,
  input  logic [SEC_W-1:0] settle_sec,
  output rds_state_t       st_nxt,
  output rds_res_t         res
);

  function automatic logic [SEC_W-1:0] phase_len(
    input logic [2:0]       p,
    input logic [SEC_W-1:0] l_load,
    input logic [SEC_W-1:0] l_poison,
    input logic [SEC_W-1:0] l_rinse,
    input logic [SEC_W-1:0] l_settle
  );
    logic [SEC_W-1:0] len;
    unique case (p)
      PH_LOAD:   len = l_load;
      PH_POISON: len = l_poison;
      PH_RINSE:  len = l_rinse;
      PH_SETTLE: len = l_settle;
      default:   len = '0;
    endcase
    return len;
  endfunction

  function automatic logic is_run(input logic [2:0] p);
    return (p >= PH_LOAD) && (p <= PH_SETTLE);
  endfunction

  // enter phase p, skipping phases of zero length; past settle goes idle
  function automatic rds_state_t enter_phase(
    input logic [2:0]       start,
    input logic [SEC_W-1:0] l_load,
    input logic [SEC_W-1:0] l_poison,
    input logic [SEC_W-1:0] l_rinse,
    input logic [SEC_W-1:0] l_settle,
    input rds_state_t       base
  );
    logic [2:0] p;
    rds_state_t s;
    s = base;
    p = start;
    for (int i = 0; i < 4; i++) begin
      if (is_run(p) && (phase_len(p, l_load, l_poison, l_rinse, l_settle) == '0)) begin
        p = p + 3'd1;
      end
    end
    if (is_run(p)) begin
      s.phase        = phase_t'(p);
      s.seconds_left = phase_len(p, l_load, l_poison, l_rinse, l_settle);
    end else begin
      s.phase        = PH_IDLE;
      s.seconds_left = '0;
    end
    return s;
  endfunction

  logic busy_now;
  logic busy_next;

  assign busy_now = is_run(st.phase);

  always_comb begin
    st_nxt          = st;
    res             = '0;
    if (item.force_request) begin
      st_nxt.forced_pending = 1'b1;
    end

    if (!item.cmd) begin
      // one-second tick
      if (busy_now) begin
        if (st.seconds_left > 8'd1) begin
          st_nxt.seconds_left = st.seconds_left - 8'd1;
        end else begin
          st_nxt = enter_phase(st.phase + 3'd1, load_sec, poison_sec, rinse_sec,
                               settle_sec, st_nxt);
        end
      end
    end else if (busy_now) begin
      res.dropped = 1'b1;
    end else begin
      unique case (item.msg_byte)
        CH_STATUS: begin
          st_nxt.tank_empty = 1'b0;
          res.reply_valid   = 1'b1;
          if (st_nxt.forced_pending) begin
            res.reply_char        = CH_FORCED;
            st_nxt.forced_pending = 1'b0;
          end else if (item.rain_wet && item.sensor_enabled) begin
            res.reply_char = CH_RAIN;
          end else begin
            res.reply_char = CH_STATUS;
          end
        end
        CH_DOSE: begin
          st_nxt = enter_phase(PH_LOAD, load_sec, poison_sec, rinse_sec,
                               settle_sec, st_nxt);
        end
        CH_PANIC: begin
          st_nxt.phase        = PH_IDLE;
          st_nxt.seconds_left = '0;
        end
        CH_VOID: begin
          st_nxt.tank_empty = 1'b1;
        end
        default: begin
        end
      endcase
    end

    busy_next    = is_run(st_nxt.phase);
    res.busy_res = busy_next;

    priority if (busy_next) begin
      res.led_n = LED_BUSY;
    end else if (st_nxt.tank_empty) begin
      res.led_n = LED_EMPTY;
    end else if (!item.sensor_enabled) begin
      res.led_n = LED_BYPASS;
    end else if (item.rain_wet) begin
      res.led_n = LED_RAIN;
    end else begin
      res.led_n = LED_READY;
    end

    unique case (st_nxt.phase)
      PH_LOAD:   res.relays_on = RELAY_WATER;
      PH_POISON: res.relays_on = RELAY_POISON;
      PH_RINSE:  res.relays_on = RELAY_WATER;
      default:   res.relays_on = RELAY_OFF;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/relay_dose_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// relay_dose_sequencer
// Pump, valve and poison relay sequencer driven by one-second ticks and
// one-byte radio commands, with reply and led status per item.
// ----------------------------------------------------------------------------
// a result is registered and valid in the cycle after its item is accepted
// throughput: one item per cycle; the state update is a single register stage
// and the result register frees up whenever the downstream side takes its item
// reset (rst_n low, synchronous): sequence idle, flags cleared, load/poison/
// rinse times back to 5/8/17 s, no result pending
module relay_dose_sequencer import rds_pkg::*; #(
  parameter logic [SEC_W-1:0] SETTLE_SECONDS = SETTLE_SECONDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rds_in_if.sink    in_ch,
  rds_out_if.source out_ch,
  rds_cfg_if.sink   cfg_ch
);

  logic [SEC_W-1:0] load_sec_r;
  logic [SEC_W-1:0] poison_sec_r;
  logic [SEC_W-1:0] rinse_sec_r;

  rds_state_t st_r;
  rds_state_t st_nxt;
  rds_item_t  item;
  rds_res_t   res_nxt;
  rds_res_t   res_r;
  logic       out_valid_r;
  logic       in_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_sec_r   <= LOAD_SECONDS_RST;
      poison_sec_r <= POISON_SECONDS_RST;
      rinse_sec_r  <= RINSE_SECONDS_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_LOAD_SECONDS) begin
        load_sec_r <= cfg_ch.data;
      end
      if (cfg_ch.index == REG_POISON_SECONDS) begin
        poison_sec_r <= cfg_ch.data;
      end
      if (cfg_ch.index == REG_RINSE_SECONDS) begin
        rinse_sec_r <= cfg_ch.data;
      end
    end
  end

  // a new item enters whenever the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign item.cmd            = in_ch.cmd;
  assign item.msg_byte       = in_ch.msg_byte;
  assign item.rain_wet       = in_ch.rain_wet;
  assign item.sensor_enabled = in_ch.sensor_enabled;
  assign item.force_request  = in_ch.force_request;

  rds_step u_step (
    .st         (st_r),
    .item       (item),
    .load_sec   (load_sec_r),
    .poison_sec (poison_sec_r),
    .rinse_sec  (rinse_sec_r),
    .settle_sec (SETTLE_SECONDS),
    .st_nxt     (st_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{phase: PH_IDLE, seconds_left: '0, tank_empty: 1'b0,
                       forced_pending: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.relays_on   = res_r.relays_on;
  assign out_ch.reply_valid = res_r.reply_valid;
  assign out_ch.reply_char  = res_r.reply_char;
  assign out_ch.led_n       = res_r.led_n;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.dropped     = res_r.dropped;

endmodule
`default_nettype wire

FILE: rtl/rds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rds_checker
// Port-level checks on the result channel of the relay dose sequencer.
// ----------------------------------------------------------------------------
module rds_checker import rds_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [RELAY_W-1:0] relays_on,
  input wire logic               reply_valid,
  input wire logic [BYTE_W-1:0]  reply_char,
  input wire logic [LED_W-1:0]   led_n,
  input wire logic               busy_res,
  input wire logic               dropped
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // reply byte is one of the three answers, zero otherwise
  a_reply_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (reply_valid ? (reply_char == CH_STATUS || reply_char == CH_RAIN ||
                                  reply_char == CH_FORCED)
                               : (reply_char == '0)))
    else $error("bad reply character");

  // relays are only energized during a sequence, spare never
  a_relays_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !relays_on[3] && ((relays_on == RELAY_OFF) || busy_res))
    else $error("relay energized outside a sequence");

  // busy led shown exactly while the sequence runs
  a_led_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy_res == (led_n == LED_BUSY)))
    else $error("led does not match busy state");

  // a dropped command leaves the sequence running and sends no reply
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> busy_res && !reply_valid)
    else $error("dropped command with idle sequence or reply");

endmodule

bind relay_dose_sequencer rds_checker u_rds_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .relays_on   (out_ch.relays_on),
  .reply_valid (out_ch.reply_valid),
  .reply_char  (out_ch.reply_char),
  .led_n       (out_ch.led_n),
  .busy_res    (out_ch.busy_res),
  .dropped     (out_ch.dropped)
);
`default_nettype wire

FILE: tb/relay_dose_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_dose_sequencer_test
// Self-checking bench for the relay dose sequencer: drives ticks and command
// bytes with random gaps and stalls, predicts every result item in a
// scoreboard that tracks the sequence phases, and checks it field by field.
// ----------------------------------------------------------------------------
module relay_dose_sequencer_test;
  import rds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // --------------------------------------------------------------------------
  // dose scoreboard: mirrors sequence phase, timers and flags
  // --------------------------------------------------------------------------
  class dose_scoreboard;
    phase_t           ph;
    logic [SEC_W-1:0] secs_left;
    bit               tank_empty;
    bit               forced_pending;
    logic [SEC_W-1:0] load_s;
    logic [SEC_W-1:0] poison_s;
    logic [SEC_W-1:0] rinse_s;
    rds_res_t         due_q[$];
    int               errors;
    int               n_items;
    int               n_results;
    int               n_replies;
    int               n_drops;
    int               n_doses;

    function new();
      ph             = PH_IDLE;
      secs_left      = '0;
      tank_empty     = 1'b0;
      forced_pending = 1'b0;
      load_s         = LOAD_SECONDS_RST;
      poison_s       = POISON_SECONDS_RST;
      rinse_s        = RINSE_SECONDS_RST;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_LOAD_SECONDS:   load_s   = val;
        REG_POISON_SECONDS: poison_s = val;
        REG_RINSE_SECONDS:  rinse_s  = val;
        default: ;
      endcase
    endfunction

    function logic [SEC_W-1:0] span(phase_t p);
      case (p)
        PH_LOAD:   return load_s;
        PH_POISON: return poison_s;
        PH_RINSE:  return rinse_s;
        PH_SETTLE: return SETTLE_SECONDS_DEF;
        default:   return '0;
      endcase
    endfunction

    // zero-length phases are passed over in the same item
    function void enter_phase(int p);
      while (p >= int'(PH_LOAD) && p <= int'(PH_SETTLE) && span(phase_t'(p)) == 0) p++;
      if (p > int'(PH_SETTLE)) begin
        ph        = PH_IDLE;
        secs_left = '0;
      end else begin
        ph        = phase_t'(p);
        secs_left = span(ph);
      end
    endfunction

    function void note_input(rds_item_t it);
      rds_res_t want;
      want = '0;
      n_items++;
      // the latch is set before the item is decoded, busy or not
      if (it.force_request) forced_pending = 1'b1;
      if (!it.cmd) begin
        if (busy()) begin
          if (secs_left > 1) secs_left--;
          else enter_phase(int'(ph) + 1);
        end
      end else if (busy()) begin
        want.dropped = 1'b1;
      end else begin
        case (it.msg_byte)
          CH_STATUS: begin
            tank_empty       = 1'b0;
            want.reply_valid = 1'b1;
            if (forced_pending) begin
              want.reply_char = CH_FORCED;
              forced_pending  = 1'b0;
            end else if (it.rain_wet && it.sensor_enabled) begin
              want.reply_char = CH_RAIN;
            end else begin
              want.reply_char = CH_STATUS;
            end
          end
          CH_DOSE: begin
            n_doses++;
            enter_phase(int'(PH_LOAD));
          end
          CH_PANIC: begin
            ph        = PH_IDLE;
            secs_left = '0;
          end
          CH_VOID: tank_empty = 1'b1;
          default: ;
        endcase
      end
      case (ph)
        PH_LOAD, PH_RINSE: want.relays_on = RELAY_WATER;
        PH_POISON:         want.relays_on = RELAY_POISON;
        default:           want.relays_on = RELAY_OFF;
      endcase
      if (busy())                   want.led_n = LED_BUSY;
      else if (tank_empty)          want.led_n = LED_EMPTY;
      else if (!it.sensor_enabled)  want.led_n = LED_BYPASS;
      else if (it.rain_wet)         want.led_n = LED_RAIN;
      else                          want.led_n = LED_READY;
      want.busy_res = busy();
      if (want.reply_valid) n_replies++;
      if (want.dropped) n_drops++;
      due_q.push_back(want);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("mismatch at result %0d: %s got %0h expected %0h", n_results, what, got, want);
    endtask

    task check_result(rds_res_t got);
      rds_res_t want;
      n_results++;
      if (due_q.size() == 0) begin
        report("result with nothing expected", 16'(got), 16'h0);
      end else begin
        want = due_q.pop_front();
        if (got.relays_on !== want.relays_on)
          report("relays_on", 16'(got.relays_on), 16'(want.relays_on));
        if (got.reply_valid !== want.reply_valid)
          report("reply_valid", 16'(got.reply_valid), 16'(want.reply_valid));
        if (got.reply_char !== want.reply_char)
          report("reply_char", 16'(got.reply_char), 16'(want.reply_char));
        if (got.led_n !== want.led_n)
          report("led_n", 16'(got.led_n), 16'(want.led_n));
        if (got.busy_res !== want.busy_res)
          report("busy_res", 16'(got.busy_res), 16'(want.busy_res));
        if (got.dropped !== want.dropped)
          report("dropped", 16'(got.dropped), 16'(want.dropped));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  rds_in_if  in_if ();
  rds_out_if out_if ();
  rds_cfg_if cfg_if ();

  relay_dose_sequencer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  dose_scoreboard sb;
  int             send_gap_pct;
  int             recv_stall_pct;
  int unsigned    cycle_count;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // accepted items are sampled on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.note_input(rds_item_t'{cmd: in_if.cmd, msg_byte: in_if.msg_byte,
                                  rain_wet: in_if.rain_wet,
                                  sensor_enabled: in_if.sensor_enabled,
                                  force_request: in_if.force_request});
      if (out_if.valid && out_if.ready)
        sb.check_result(rds_res_t'{relays_on: out_if.relays_on,
                                   reply_valid: out_if.reply_valid,
                                   reply_char: out_if.reply_char,
                                   led_n: out_if.led_n,
                                   busy_res: out_if.busy_res,
                                   dropped: out_if.dropped});
    end
  end

  // --------------------------------------------------------------------------
  // drive tasks
  // --------------------------------------------------------------------------
  function automatic rds_item_t make_item(bit cmd, logic [BYTE_W-1:0] msg, bit wet,
                                          bit enabled, bit force_req);
    rds_item_t it;
    it.cmd            = cmd;
    it.msg_byte       = msg;
    it.rain_wet       = wet;
    it.sensor_enabled = enabled;
    it.force_request  = force_req;
    return it;
  endfunction

  // mostly legal commands so that dose sequences run to the end
  function automatic rds_item_t rand_item(int tick_pct);
    rds_item_t it;
    int        pick;
    it.cmd = ($urandom_range(99) >= tick_pct);
    pick   = $urandom_range(99);
    if (pick < 22)      it.msg_byte = CH_DOSE;
    else if (pick < 44) it.msg_byte = CH_STATUS;
    else if (pick < 56) it.msg_byte = CH_PANIC;
    else if (pick < 70) it.msg_byte = CH_VOID;
    else                it.msg_byte = BYTE_W'($urandom_range(255));
    it.rain_wet       = 1'($urandom_range(1));
    it.sensor_enabled = 1'($urandom_range(1));
    it.force_request  = ($urandom_range(99) < 15);
    return it;
  endfunction

  task automatic send_item(input rds_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.cmd            <= it.cmd;
    in_if.msg_byte       <= it.msg_byte;
    in_if.rain_wet       <= it.rain_wet;
    in_if.sensor_enabled <= it.sensor_enabled;
    in_if.force_request  <= it.force_request;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_timing(input logic [CFG_DAT_W-1:0] load_s, poison_s, rinse_s);
    logic [CFG_IDX_W-1:0] regs [3];
    logic [CFG_DAT_W-1:0] vals [3];
    regs[0] = REG_LOAD_SECONDS;
    regs[1] = REG_POISON_SECONDS;
    regs[2] = REG_RINSE_SECONDS;
    vals[0] = load_s;
    vals[1] = poison_s;
    vals[2] = rinse_s;
    drain();
    for (int r = 0; r < 3; r++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[r];
      cfg_if.data  <= vals[r];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int gap_mix [3];
    int stall_mix [3];
    int ticks;
    rds_item_t it;

    sb                   = new();
    cycle_count          = 0;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cmd            = 1'b0;
    in_if.msg_byte       = '0;
    in_if.rain_wet       = 1'b0;
    in_if.sensor_enabled = 1'b0;
    in_if.force_request  = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    gap_mix[0]   = 33;
    stall_mix[0] = 49;
    gap_mix[1]   = 49;
    stall_mix[1] = 33;
    gap_mix[2]   = 0;
    stall_mix[2] = 0;
    send_gap_pct   = gap_mix[0];
    recv_stall_pct = stall_mix[0];

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // idle behavior under reset timing
    send_item(make_item(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_STATUS, 1'b1, 1'b0, 1'b0));
    send_item(make_item(1'b1, CH_STATUS, 1'b1, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_VOID, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_STATUS, 1'b1, 1'b1, 1'b1));
    send_item(make_item(1'b0, 8'hFF, 1'b0, 1'b1, 1'b1));
    send_item(make_item(1'b1, CH_STATUS, 1'b1, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_STATUS, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 8'hFF, 1'b1, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_PANIC, 1'b0, 1'b0, 1'b0));

    // all phases zero: dose drops straight into settle
    program_timing(8'd0, 8'd0, 8'd0);
    send_item(make_item(1'b1, CH_DOSE, 1'b0, 1'b0, 1'b0));
    repeat (3) send_item(make_item(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));

    // empty poison phase skipped mid-sequence, commands dropped while busy
    program_timing(8'd1, 8'd0, 8'd2);
    send_item(make_item(1'b1, CH_DOSE, 1'b1, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_STATUS, 1'b1, 1'b1, 1'b0));
    send_item(make_item(1'b1, CH_PANIC, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
    repeat (5) send_item(make_item(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(make_item(1'b1, CH_STATUS, 1'b1, 1'b1, 1'b0));

    // random part: three idle mixes, four timing settings each
    for (int m = 0; m < 3; m++) begin
      send_gap_pct   = gap_mix[m];
      recv_stall_pct = stall_mix[m];
      for (int s = 0; s < 4; s++) begin
        case (m * 4 + s)
          0:  program_timing(LOAD_SECONDS_RST, POISON_SECONDS_RST, RINSE_SECONDS_RST);
          2:  program_timing(8'd1, 8'd1, 8'd1);
          4:  program_timing(8'd0, 8'd0, 8'd0);
          6:  program_timing(8'd0, 8'd255, 8'd0);
          9:  program_timing(8'd2, 8'd0, 8'd3);
          default: program_timing(CFG_DAT_W'($urandom_range(4)),
                                  CFG_DAT_W'($urandom_range(4)),
                                  CFG_DAT_W'($urandom_range(4)));
        endcase
        repeat (40) send_item(rand_item(60));
      end
    end

    // full-length sequence at the largest timing: finish any sequence first
    drain();
    while (sb.busy()) begin
      send_item(rand_item(100));
      drain();
    end
    program_timing(8'd255, 8'd255, 8'd255);
    it     = rand_item(0);
    it.msg_byte = CH_DOSE;
    send_item(it);
    ticks = 0;
    while (ticks < 3 * 255 + int'(SETTLE_SECONDS_DEF)) begin
      it = rand_item(90);
      if (!it.cmd) ticks++;
      send_item(it);
    end
    send_item(make_item(1'b1, CH_STATUS, 1'b0, 1'b1, 1'b0));

    drain();
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never seen", 16'(sb.pending()), 16'h0);

    $display("ran %0d items, %0d results checked: %0d dose starts, %0d replies, %0d drops",
             sb.n_items, sb.n_results, sb.n_doses, sb.n_replies, sb.n_drops);
    $display("timings from all zero to all 255 under three gap/stall mixes, %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
